[rtl/pen_pkg.sv]
// ----------------------------------------------------------------------------
// pen_pkg: shared types and constants for the polygon edge neighbor finder
// Field widths, operation and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package pen_pkg;

  // Default capacities
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_POLYGONS_DEF = 256;

  // Fixed field widths
  localparam int COORD_W  = 32;
  localparam int POLY_W   = 8;
  localparam int EDGE_W   = 10;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  // Item operations
  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  // Query result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND = 2'd0,
    ST_NONE  = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  // Vertex read address select
  typedef enum logic [1:0] {
    RD_A    = 2'd0,
    RD_B    = 2'd1,
    RD_SCAN = 2'd2
  } rd_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    capture;
    logic    clear;
    logic    load;
    rd_sel_t rd_sel;
    logic    latch_a;
    logic    latch_b;
    logic    scan_init;
    logic    scan;
    logic    set_bad;
    logic    set_none;
    logic    out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad;
    logic hit;
    logic scan_fin;
  } dp_status_t;

endpackage

[rtl/pen_dpath.sv]
// ----------------------------------------------------------------------------
// pen_dpath: polygon store and edge search datapath
// Holds the vertex ring store and polygon tables, performs loads and clears,
// and walks the closed vertices comparing against the query edge until a hit.
// ----------------------------------------------------------------------------
module pen_dpath #(
  parameter int MAX_VERTICES = pen_pkg::MAX_VERTICES_DEF,
  parameter int MAX_POLYGONS = pen_pkg::MAX_POLYGONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pen_pkg::ctrl_cmd_t                cmd,
  input  logic signed [pen_pkg::COORD_W-1:0] in_x,
  input  logic signed [pen_pkg::COORD_W-1:0] in_y,
  input  logic                              in_last,
  input  logic [pen_pkg::POLY_W-1:0]        in_poly,
  input  logic [pen_pkg::EDGE_W-1:0]        in_edge,
  output pen_pkg::dp_status_t               st,
  output pen_pkg::status_t                  out_status,
  output logic [pen_pkg::POLY_W-1:0]        out_poly,
  output logic [pen_pkg::EDGE_W-1:0]        out_edge,
  output logic                              out_ovf
);
  import pen_pkg::*;

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
  localparam int PIDX_W = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
  localparam int PCNT_W = $clog2(MAX_POLYGONS + 1);
  localparam int QW     = (PCNT_W > POLY_W) ? PCNT_W : POLY_W;
  localparam int PW     = (PIDX_W > POLY_W) ? PIDX_W : POLY_W;
  localparam int EW     = ((VCNT_W > EDGE_W) ? VCNT_W : EDGE_W) + 1;
  localparam int VTX_W  = 2 * COORD_W;
  localparam int VMEM_W = VTX_W + 1;

  // Store bookkeeping
  logic [VCNT_W-1:0] vc_r, open_r;
  logic [PCNT_W-1:0] pc_r;
  logic              ovf_r;
  logic              full;
  logic [VCNT_W-1:0] vc_inc;

  // Memories and registered read data
  logic [VMEM_W-1:0] vmem [MAX_VERTICES];
  logic [VIDX_W-1:0] pstart_mem [MAX_POLYGONS];
  logic [VCNT_W-1:0] plen_mem [MAX_POLYGONS];
  logic [VMEM_W-1:0] vtx_q;
  logic [VIDX_W-1:0] pstart_q;
  logic [VCNT_W-1:0] plen_q;

  // Query registers
  logic [POLY_W-1:0] pi_r;
  logic [EDGE_W-1:0] ei_r;
  logic [VTX_W-1:0]  a_r, b_r;
  logic [PIDX_W-1:0] pi_addr;
  logic [EW-1:0]     ei_sum, pos_b;
  logic [VIDX_W-1:0] addr_a, addr_b, rd_addr;

  // Scan state
  logic [VCNT_W-1:0] scan_addr_r;
  logic              vld_r;
  logic [VIDX_W-1:0] pos_r;
  logic [PIDX_W-1:0] poly_r;
  logic              prev_b_r, first_a_r;
  logic              issue, eq_a, eq_b, first_a, m_prev, m_wrap, own, hit, vlast;
  logic [VTX_W-1:0]  vtx;
  logic [VIDX_W-1:0] hit_edge;

  // Result and output registers
  status_t           res_status_r, out_status_r;
  logic [PIDX_W-1:0] res_poly_r;
  logic [VIDX_W-1:0] res_edge_r;
  logic [POLY_W-1:0] out_poly_r;
  logic [EDGE_W-1:0] out_edge_r;
  logic              out_ovf_r;

  // Load capacity check
  assign full   = (vc_r == VCNT_W'(MAX_VERTICES)) || (pc_r == PCNT_W'(MAX_POLYGONS));
  assign vc_inc = vc_r + VCNT_W'(1);

  // Counters and sticky overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r   <= '0;
      pc_r   <= '0;
      open_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.clear) begin
      vc_r   <= '0;
      pc_r   <= '0;
      open_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        vc_r <= vc_inc;
        if (in_last) begin
          pc_r   <= pc_r + PCNT_W'(1);
          open_r <= vc_inc;
        end
      end
    end
  end

  // Vertex store: tag bit marks the closing vertex of a polygon
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      vmem[vc_r[VIDX_W-1:0]] <= {in_last, in_y, in_x};
    end
    vtx_q <= vmem[rd_addr];
  end

  // Polygon tables
  always_ff @(posedge clk) begin
    if (cmd.load && !full && in_last) begin
      pstart_mem[pc_r[PIDX_W-1:0]] <= open_r[VIDX_W-1:0];
      plen_mem[pc_r[PIDX_W-1:0]]   <= vc_inc - open_r;
    end
    pstart_q <= pstart_mem[pi_addr];
    plen_q   <= plen_mem[pi_addr];
  end

  // Query capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pi_r <= in_poly;
      ei_r <= in_edge;
    end
    if (cmd.latch_a) a_r <= vtx_q[VTX_W-1:0];
    if (cmd.latch_b) b_r <= vtx_q[VTX_W-1:0];
  end

  assign pi_addr = PIDX_W'(PW'(pi_r));

  // Query edge endpoints and validity
  assign ei_sum = EW'(ei_r) + EW'(1);
  assign pos_b  = (ei_sum == EW'(plen_q)) ? '0 : ei_sum;
  assign addr_a = VIDX_W'(EW'(pstart_q) + EW'(ei_r));
  assign addr_b = VIDX_W'(EW'(pstart_q) + pos_b);
  assign st.bad = !((QW'(pi_r) < QW'(pc_r)) && (EW'(ei_r) < EW'(plen_q)));

  // Vertex read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_A:    rd_addr = addr_a;
      RD_B:    rd_addr = addr_b;
      default: rd_addr = scan_addr_r[VIDX_W-1:0];
    endcase
  end

  // Edge compare: edge l matches when vertex l equals B and vertex l+1 equals A
  assign vtx      = vtx_q[VTX_W-1:0];
  assign vlast    = vtx_q[VTX_W];
  assign eq_a     = (vtx == a_r);
  assign eq_b     = (vtx == b_r);
  assign first_a  = (pos_r == '0) ? eq_a : first_a_r;
  assign m_prev   = (pos_r != '0) && prev_b_r && eq_a;
  assign m_wrap   = vlast && eq_b && first_a;
  assign own      = (PW'(poly_r) == PW'(pi_r));
  assign hit      = vld_r && !own && (m_prev || m_wrap);
  assign hit_edge = m_prev ? (pos_r - VIDX_W'(1)) : pos_r;
  assign issue    = (scan_addr_r < open_r);

  assign st.hit      = hit;
  assign st.scan_fin = !vld_r && !issue;

  // Scan walk over closed vertices, one read per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (cmd.scan_init) begin
      scan_addr_r <= '0;
      vld_r       <= 1'b0;
      pos_r       <= '0;
      poly_r      <= '0;
      prev_b_r    <= 1'b0;
      first_a_r   <= 1'b0;
    end else if (cmd.scan) begin
      vld_r <= issue;
      if (issue) scan_addr_r <= scan_addr_r + VCNT_W'(1);
      if (vld_r) begin
        prev_b_r  <= eq_b;
        first_a_r <= first_a;
        if (vlast) begin
          pos_r  <= '0;
          poly_r <= poly_r + PIDX_W'(1);
        end else begin
          pos_r <= pos_r + VIDX_W'(1);
        end
      end
    end else begin
      vld_r <= 1'b0;
    end
  end

  // Result capture
  always_ff @(posedge clk) begin
    if (cmd.set_bad) begin
      res_status_r <= ST_BAD;
      res_poly_r   <= '0;
      res_edge_r   <= '0;
    end else if (cmd.set_none) begin
      res_status_r <= ST_NONE;
      res_poly_r   <= '0;
      res_edge_r   <= '0;
    end else if (cmd.scan && hit) begin
      res_status_r <= ST_FOUND;
      res_poly_r   <= poly_r;
      res_edge_r   <= hit_edge;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_poly_r   <= POLY_W'(res_poly_r);
      out_edge_r   <= EDGE_W'(res_edge_r);
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_status = out_status_r;
  assign out_poly   = out_poly_r;
  assign out_edge   = out_edge_r;
  assign out_ovf    = out_ovf_r;

endmodule

[rtl/pen_ctrl.sv]
// ----------------------------------------------------------------------------
// pen_ctrl: sequencing controller
// Accepts items, steps a query through lookup, endpoint reads and the edge
// scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module pen_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  pen_pkg::action_t    in_action,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  pen_pkg::dp_status_t st,
  output pen_pkg::ctrl_cmd_t  cmd
);
  import pen_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOOKUP = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_RDA    = 7'b0001000,
    S_RDB    = 7'b0010000,
    S_SCAN   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_SCAN;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_action)
            ACT_CLEAR: cmd.clear = 1'b1;
            ACT_LOAD:  cmd.load  = 1'b1;
            ACT_QUERY: begin
              cmd.capture = 1'b1;
              state_nxt   = S_LOOKUP;
            end
            default: ;
          endcase
        end
      end
      S_LOOKUP: state_nxt = S_CHECK;
      S_CHECK: begin
        cmd.rd_sel = RD_A;
        if (st.bad) begin
          cmd.set_bad = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        cmd.latch_a = 1'b1;
        cmd.rd_sel  = RD_B;
        state_nxt   = S_RDB;
      end
      S_RDB: begin
        cmd.latch_b   = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.hit) begin
          state_nxt = S_DONE;
        end else if (st.scan_fin) begin
          cmd.set_none = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared on transfer
  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

[rtl/polygon_edge_neighbor_finder.sv]
// ----------------------------------------------------------------------------
// polygon_edge_neighbor_finder: finds the polygon sharing a reversed edge
// Stores polygons as vertex rings and answers edge adjacency queries.
//
// Usage:
//   Input stream carries one item per transfer; in_tuser selects clear,
//   load vertex or query. A load stores (x, y); in_tlast closes the polygon.
//   Loads beyond capacity are dropped and set a sticky overflow flag.
//   A query names a polygon and edge; the block returns one result on the
//   output stream: status in out_tuser, neighbor polygon, edge, overflow.
//   Clear and load are done at their transfer. A query goes through lookup,
//   check, two endpoint reads and a scan of closed vertices, one memory
//   read per scan cycle, a hit ending it early; a bad query skips to done.
//   Items are taken one at a time; a new item is accepted while the last
//   result still waits in the output register. When the receiver stalls a
//   finished query holds until the output register frees up.
//   Reset empties the store and clears overflow; memories are not cleared.
// ----------------------------------------------------------------------------
module polygon_edge_neighbor_finder #(
  parameter int MAX_VERTICES = pen_pkg::MAX_VERTICES_DEF,
  parameter int MAX_POLYGONS = pen_pkg::MAX_POLYGONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // x[31:0], y[63:32], poly_index[71:64], edge_index[81:72], zero fill
  input  logic [87:0] in_tdata,
  // action[1:0]
  input  logic [pen_pkg::ACTION_W-1:0] in_tuser,
  // last_vertex
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // neighbor_poly[7:0], neighbor_edge[17:8], overflow[18], zero fill
  output logic [23:0] out_tdata,
  // status[1:0]
  output logic [pen_pkg::STATUS_W-1:0] out_tuser
);
  import pen_pkg::*;

  ctrl_cmd_t         cmd;
  dp_status_t        st;
  status_t           res_status;
  logic [POLY_W-1:0] res_poly;
  logic [EDGE_W-1:0] res_edge;
  logic              res_ovf;

  pen_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (action_t'(in_tuser)),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  pen_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_POLYGONS (MAX_POLYGONS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_x       (in_tdata[31:0]),
    .in_y       (in_tdata[63:32]),
    .in_last    (in_tlast),
    .in_poly    (in_tdata[71:64]),
    .in_edge    (in_tdata[81:72]),
    .st         (st),
    .out_status (res_status),
    .out_poly   (res_poly),
    .out_edge   (res_edge),
    .out_ovf    (res_ovf)
  );

  // Result packing
  assign out_tuser = res_status;
  assign out_tdata = {5'd0, res_ovf, res_edge, res_poly};

endmodule
